>>> design/sgi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgi_pkg;

  localparam int unsigned MUL_DIGIT      = 32;
  localparam int unsigned TOL_WIDTH      = 31;
  localparam int unsigned THR_WIDTH      = 16;
  localparam int unsigned PAR_SHIFT      = 32;
  localparam int unsigned CFG_IDX_WIDTH  = 4;
  localparam int unsigned CFG_DATA_WIDTH = 32;

  localparam logic [TOL_WIDTH-1:0] TOL_RESET = '0;
  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(4);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_TOL = CFG_IDX_WIDTH'(0),
    CFG_THR = CFG_IDX_WIDTH'(1)
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> design/sgi_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module sgi_mul #(
  parameter int unsigned A_WIDTH = 32,
  parameter int unsigned B_WIDTH = 32,
  parameter int unsigned LATENCY = 1
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [A_WIDTH-1:0]         a_i,
  input  logic [B_WIDTH-1:0]         b_i,
  output logic [A_WIDTH+B_WIDTH-1:0] p_o
);
  import sgi_pkg::*;

  localparam int unsigned Dg = MUL_DIGIT;
  localparam int unsigned NA = (A_WIDTH + Dg - 1) / Dg;
  localparam int unsigned NB = (B_WIDTH + Dg - 1) / Dg;
  localparam int unsigned PW = A_WIDTH + B_WIDTH;
  localparam int unsigned XA = NA * Dg;
  localparam int unsigned XB = NB * Dg;

  logic [XA-1:0] a_q   [LATENCY];
  logic [XB-1:0] b_q   [LATENCY];
  logic [PW-1:0] acc_q [LATENCY];

  for (genvar k = 0; k < LATENCY; k++) begin : g_stage
    logic [XA-1:0] a_in;
    logic [XB-1:0] b_in;
    logic [PW-1:0] acc_in;
    logic [PW-1:0] acc_d;

    if (k == 0) begin : g_first
      assign a_in   = XA'(a_i);
      assign b_in   = XB'(b_i);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[k-1];
      assign b_in   = b_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    if (k < NA * NB) begin : g_pp
      localparam int unsigned AI = k / NB;
      localparam int unsigned BI = k % NB;
      localparam int unsigned SH = Dg * (AI + BI);
      logic [2*Dg-1:0] pp;
      assign pp    = a_in[AI*Dg +: Dg] * b_in[BI*Dg +: Dg];
      assign acc_d = acc_in + PW'({{PW{1'b0}}, pp} << SH);
    end else begin : g_pad
      assign acc_d = acc_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]   <= a_in;
        b_q[k]   <= b_in;
        acc_q[k] <= acc_d;
      end
    end
  end

  assign p_o = acc_q[LATENCY-1];

endmodule

`default_nettype wire

>>> design/sgi_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sgi_div #(
  parameter int unsigned N_WIDTH = 101,
  parameter int unsigned D_WIDTH = 67,
  parameter int unsigned Q_WIDTH = 33,
  parameter int unsigned LATENCY = 34
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [N_WIDTH-1:0] num_i,
  input  logic [D_WIDTH-1:0] den_i,
  output logic [Q_WIDTH-1:0] quo_o,
  output logic               ovf_o
);

  localparam int unsigned RW  = D_WIDTH + 1;
  localparam int unsigned HW  = N_WIDTH - Q_WIDTH;
  localparam int unsigned CWD = (HW > D_WIDTH) ? HW : D_WIDTH;

  logic [RW-1:0]      r_q   [LATENCY];
  logic [Q_WIDTH-1:0] lo_q  [LATENCY];
  logic [Q_WIDTH-1:0] q_q   [LATENCY];
  logic [D_WIDTH-1:0] d_q   [LATENCY];
  logic               ovf_q [LATENCY];

  for (genvar k = 0; k < LATENCY; k++) begin : g_stage
    logic [RW-1:0]      r_d;
    logic [Q_WIDTH-1:0] lo_d;
    logic [Q_WIDTH-1:0] q_d;
    logic [D_WIDTH-1:0] d_d;
    logic               ovf_d;

    if (k == 0) begin : g_first
      logic [HW-1:0] hi;
      assign hi    = num_i[N_WIDTH-1:Q_WIDTH];
      assign ovf_d = CWD'(hi) >= CWD'(den_i);
      assign r_d   = RW'(hi);
      assign lo_d  = num_i[Q_WIDTH-1:0];
      assign q_d   = '0;
      assign d_d   = den_i;
    end else if (k <= Q_WIDTH) begin : g_step
      logic [RW-1:0] t;
      logic          ge;
      assign t     = {r_q[k-1][RW-2:0], lo_q[k-1][Q_WIDTH-k]};
      assign ge    = t >= {1'b0, d_q[k-1]};
      assign r_d   = ge ? (t - {1'b0, d_q[k-1]}) : t;
      assign lo_d  = lo_q[k-1];
      assign d_d   = d_q[k-1];
      assign ovf_d = ovf_q[k-1];
      always_comb begin
        q_d              = q_q[k-1];
        q_d[Q_WIDTH-k]   = ge;
      end
    end else begin : g_pad
      assign r_d   = r_q[k-1];
      assign lo_d  = lo_q[k-1];
      assign q_d   = q_q[k-1];
      assign d_d   = d_q[k-1];
      assign ovf_d = ovf_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= r_d;
        lo_q[k]  <= lo_d;
        q_q[k]   <= q_d;
        d_q[k]   <= d_d;
        ovf_q[k] <= ovf_d;
      end
    end
  end

  assign quo_o = q_q[LATENCY-1];
  assign ovf_o = ovf_q[LATENCY-1];

endmodule

`default_nettype wire

>>> design/segment_intersection_2d_top.sv
// Intersection of two 2D segments given as signed fixed-point endpoints.
// Requests enter on the s_axis channel, one pair of segments per transfer, and
// one result leaves on the m_axis channel for every request, in order.
// The m_axis_tuser_o bit is the hit flag; on a miss the point is zero.
// Configuration writes use the cfg channel, which is always ready: index 0 is
// the segment tolerance, index 1 the parallel threshold. Other indexes are
// ignored. Write them only while no request is in flight.
// Throughput is one request per cycle while the output is not held back. The
// pipeline length is set by the chains of 32x32 partial products in the wide
// multipliers and by the restoring divider, which resolves one quotient bit
// per stage for the rounded intersection point.
// The whole pipeline advances together: when the output holds a result that is
// not taken, every stage holds and s_axis_tready_o is low, so nothing is lost
// or repeated. Reset empties the pipeline and loads the register defaults,
// tolerance zero and threshold four.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_2d_top #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_WIDTH-1:0]              s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // cross_x, cross_y, zero fill
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata_o,
  // hit
  output logic                                  m_axis_tuser_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sgi_pkg::CFG_IDX_WIDTH-1:0]     cfg_index_i,
  input  logic [sgi_pkg::CFG_DATA_WIDTH-1:0]    cfg_data_i
);
  import sgi_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned MW   = 2 * DW;
  localparam int unsigned LW   = MW;
  localparam int unsigned NW   = MW + 1;
  localparam int unsigned QW   = W + 1;
  localparam int unsigned TW   = TOL_WIDTH;
  localparam int unsigned XW   = 2 * MW + LW;
  localparam int unsigned YW   = 2 * TW + 2 * MW;
  localparam int unsigned CW   = (XW > YW) ? XW : YW;
  localparam int unsigned PCW  = MW + PAR_SHIFT;
  localparam int unsigned NWD  = MW + DW + 2;
  localparam int unsigned TDW  = ((2 * W + 7) / 8) * 8;
  localparam int unsigned NDW  = (DW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned NMW  = (MW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned NM2  = (2 * MW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned NT2  = (2 * TW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned LB   = NDW * NDW;
  localparam int unsigned LD   = NMW * NMW;
  localparam int unsigned LE0  = NM2 * NMW;
  localparam int unsigned LE1  = NT2 * NM2;
  localparam int unsigned LEA  = (LE0 > LE1) ? LE0 : LE1;
  localparam int unsigned LE   = (LEA > QW + 1) ? LEA : QW + 1;
  localparam int unsigned LTOT = LB + LD + LE + 6;

  localparam int unsigned IAX = 0, IAY = 1, IAEX = 2, IAEY = 3;
  localparam int unsigned IBX = 4, IBY = 5, IBEX = 6, IBEY = 7;
  localparam int unsigned DAX = 0, DAY = 1, DBX = 2, DBY = 3, WX = 4, WY = 5;
  localparam int PA [10] = '{DAY, DAX, WY, WX, WY, WX, DAX, DAY, DBX, DBY};
  localparam int PB [10] = '{DBX, DBY, DBX, DBY, DAX, DAY, DAX, DAY, DBX, DBY};

  localparam logic [W-1:0]          CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]          CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+2:0]   SMAX = (W+3)'(CMAX);
  localparam logic signed [W+2:0]   SMIN = -SMAX - 1;

  typedef struct packed {
    logic [W-1:0]  base_x;
    logic [W-1:0]  base_y;
    logic [5:0]    sgn;
    logic [DW-1:0] dax_m;
    logic [DW-1:0] day_m;
  } sb_t;

  typedef struct packed {
    logic [W-1:0]  base_x;
    logic [W-1:0]  base_y;
    logic          dax_s;
    logic          day_s;
    logic [DW-1:0] dax_m;
    logic [DW-1:0] day_m;
  } cs_t;

  typedef struct packed {
    logic [MW-1:0] det_m;
    logic [LW-1:0] la;
    logic [LW-1:0] lb;
    logic          zero;
    logic [W-1:0]  base_x;
    logic [W-1:0]  base_y;
    logic          neg_x;
    logic          neg_y;
  } sd_t;

  typedef struct packed {
    logic         zero;
    logic         par;
    logic [W-1:0] base_x;
    logic [W-1:0] base_y;
    logic         neg_x;
    logic         neg_y;
  } se_t;

  function automatic logic [DW:0] sub_sm(logic [W-1:0] a, logic [W-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'($signed(a)) - DW'($signed(b));
    return {d[DW-1], d[DW-1] ? DW'(-d) : DW'(d)};
  endfunction

  function automatic logic [W-1:0] sat_coord(logic signed [W+2:0] s, logic ovf, logic neg);
    logic [W-1:0] r;
    if (ovf) begin
      r = neg ? CMIN : CMAX;
    end else if (s > SMAX) begin
      r = CMAX;
    end else if (s < SMIN) begin
      r = CMIN;
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  logic [TW-1:0]        tol_q;
  logic [THR_WIDTH-1:0] thr_q;
  logic [LTOT-1:0]      vld_q;
  logic                 en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TOL) begin
        tol_q <= cfg_data_i[TW-1:0];
      end else if (cfg_index_i == CFG_THR) begin
        thr_q <= cfg_data_i[THR_WIDTH-1:0];
      end
    end
  end

  assign en              = !vld_q[LTOT-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[LTOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LTOT-2:0], s_axis_tvalid_i};
    end
  end

  // Differences and the delay lines that run beside the multipliers.
  logic [5:0]    dsg_q;
  logic [DW-1:0] dmag_q [6];
  logic [W-1:0]  bx_q;
  logic [W-1:0]  by_q;
  logic [DW:0]   dsm [6];

  always_comb begin
    dsm[DAX] = sub_sm(s_axis_tdata_i[IAEX*W +: W], s_axis_tdata_i[IAX*W +: W]);
    dsm[DAY] = sub_sm(s_axis_tdata_i[IAEY*W +: W], s_axis_tdata_i[IAY*W +: W]);
    dsm[DBX] = sub_sm(s_axis_tdata_i[IBEX*W +: W], s_axis_tdata_i[IBX*W +: W]);
    dsm[DBY] = sub_sm(s_axis_tdata_i[IBEY*W +: W], s_axis_tdata_i[IBY*W +: W]);
    dsm[WX]  = sub_sm(s_axis_tdata_i[IBX*W +: W], s_axis_tdata_i[IAX*W +: W]);
    dsm[WY]  = sub_sm(s_axis_tdata_i[IBY*W +: W], s_axis_tdata_i[IAY*W +: W]);
  end

  logic [2*DW-1:0] mb_p [10];

  for (genvar k = 0; k < 10; k++) begin : g_mul_b
    sgi_mul #(.A_WIDTH(DW), .B_WIDTH(DW), .LATENCY(LB)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (dmag_q[PA[k]]),
      .b_i   (dmag_q[PB[k]]),
      .p_o   (mb_p[k])
    );
  end

  sb_t sb_q [LB];
  sb_t sb_in;
  assign sb_in = '{base_x: bx_q, base_y: by_q, sgn: dsg_q,
                   dax_m: dmag_q[DAX], day_m: dmag_q[DAY]};

  logic signed [NW-1:0] term [6];
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      term[k] = (sb_q[LB-1].sgn[PA[k]] ^ sb_q[LB-1].sgn[PB[k]])
              ? -$signed(NW'(mb_p[k])) : $signed(NW'(mb_p[k]));
    end
  end

  // First stage after the cross products.
  logic signed [NW-1:0] det1_q, ns1_q, nt1_q;
  logic [LW-1:0]        la1_q, lb1_q;
  cs_t                  cs1_q;

  // Sign normalization.
  logic [MW-1:0]        detm2_q;
  logic signed [NW-1:0] ns2_q, nt2_q;
  logic [LW-1:0]        la2_q, lb2_q, mn2_q;
  logic                 zero2_q;
  cs_t                  cs2_q;

  // Overshoot beyond either segment end.
  logic [MW-1:0]        vs3_q, vt3_q, nsm3_q, detm3_q;
  logic                 nss3_q, zero3_q;
  logic [LW-1:0]        la3_q, lb3_q, mn3_q;
  cs_t                  cs3_q;

  logic signed [NW:0]   over_s, over_t;
  logic                 det_neg;
  assign det_neg = det1_q[NW-1];
  assign over_s  = (NW+1)'(ns2_q) - $signed((NW+1)'(detm2_q));
  assign over_t  = (NW+1)'(nt2_q) - $signed((NW+1)'(detm2_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        dsg_q[k]  <= dsm[k][DW];
        dmag_q[k] <= dsm[k][DW-1:0];
      end
      bx_q <= s_axis_tdata_i[IAX*W +: W];
      by_q <= s_axis_tdata_i[IAY*W +: W];

      sb_q[0] <= sb_in;
      for (int i = 1; i < LB; i++) begin
        sb_q[i] <= sb_q[i-1];
      end

      det1_q <= term[0] - term[1];
      ns1_q  <= term[2] - term[3];
      nt1_q  <= term[4] - term[5];
      la1_q  <= LW'(mb_p[6]) + LW'(mb_p[7]);
      lb1_q  <= LW'(mb_p[8]) + LW'(mb_p[9]);
      cs1_q  <= '{base_x: sb_q[LB-1].base_x, base_y: sb_q[LB-1].base_y,
                  dax_s: sb_q[LB-1].sgn[DAX], day_s: sb_q[LB-1].sgn[DAY],
                  dax_m: sb_q[LB-1].dax_m, day_m: sb_q[LB-1].day_m};

      zero2_q <= (la1_q == '0) || (lb1_q == '0) || (det1_q == '0);
      detm2_q <= det_neg ? MW'(-det1_q) : MW'(det1_q);
      ns2_q   <= det_neg ? -ns1_q : ns1_q;
      nt2_q   <= det_neg ? -nt1_q : nt1_q;
      mn2_q   <= (la1_q <= lb1_q) ? la1_q : lb1_q;
      la2_q   <= la1_q;
      lb2_q   <= lb1_q;
      cs2_q   <= cs1_q;

      vs3_q   <= ns2_q[NW-1] ? MW'(-ns2_q) : ((over_s > 0) ? MW'(over_s) : '0);
      vt3_q   <= nt2_q[NW-1] ? MW'(-nt2_q) : ((over_t > 0) ? MW'(over_t) : '0);
      nsm3_q  <= ns2_q[NW-1] ? MW'(-ns2_q) : MW'(ns2_q);
      nss3_q  <= ns2_q[NW-1];
      detm3_q <= detm2_q;
      zero3_q <= zero2_q;
      la3_q   <= la2_q;
      lb3_q   <= lb2_q;
      mn3_q   <= mn2_q;
      cs3_q   <= cs2_q;
    end
  end

  // Squares, threshold product and point numerators.
  logic [THR_WIDTH+LW-1:0] thr_mn;
  logic [2*MW-1:0]         det2, vs2, vt2;
  logic [2*TW-1:0]         tol2;
  logic [MW+DW-1:0]        px, py;

  sgi_mul #(.A_WIDTH(THR_WIDTH), .B_WIDTH(LW), .LATENCY(LD)) u_mul_thr (
    .clk_i(clk_i), .en_i(en), .a_i(thr_q), .b_i(mn3_q), .p_o(thr_mn));
  sgi_mul #(.A_WIDTH(MW), .B_WIDTH(MW), .LATENCY(LD)) u_mul_det2 (
    .clk_i(clk_i), .en_i(en), .a_i(detm3_q), .b_i(detm3_q), .p_o(det2));
  sgi_mul #(.A_WIDTH(TW), .B_WIDTH(TW), .LATENCY(LD)) u_mul_tol2 (
    .clk_i(clk_i), .en_i(en), .a_i(tol_q), .b_i(tol_q), .p_o(tol2));
  sgi_mul #(.A_WIDTH(MW), .B_WIDTH(MW), .LATENCY(LD)) u_mul_vs2 (
    .clk_i(clk_i), .en_i(en), .a_i(vs3_q), .b_i(vs3_q), .p_o(vs2));
  sgi_mul #(.A_WIDTH(MW), .B_WIDTH(MW), .LATENCY(LD)) u_mul_vt2 (
    .clk_i(clk_i), .en_i(en), .a_i(vt3_q), .b_i(vt3_q), .p_o(vt2));
  sgi_mul #(.A_WIDTH(MW), .B_WIDTH(DW), .LATENCY(LD)) u_mul_px (
    .clk_i(clk_i), .en_i(en), .a_i(nsm3_q), .b_i(cs3_q.dax_m), .p_o(px));
  sgi_mul #(.A_WIDTH(MW), .B_WIDTH(DW), .LATENCY(LD)) u_mul_py (
    .clk_i(clk_i), .en_i(en), .a_i(nsm3_q), .b_i(cs3_q.day_m), .p_o(py));

  sd_t sd_q [LD];
  sd_t sd_in;
  assign sd_in = '{det_m: detm3_q, la: la3_q, lb: lb3_q, zero: zero3_q,
                   base_x: cs3_q.base_x, base_y: cs3_q.base_y,
                   neg_x: nss3_q ^ cs3_q.dax_s, neg_y: nss3_q ^ cs3_q.day_s};

  // Tolerance products and the rounded divisions for the point.
  logic [XW-1:0]  xs, xt;
  logic [YW-1:0]  yv;
  logic [QW-1:0]  qx, qy;
  logic           ovfx, ovfy;
  logic [NWD-1:0] numx, numy;
  logic [MW:0]    den;
  sd_t            sdo;

  assign sdo  = sd_q[LD-1];
  assign numx = (NWD'(px) << 1) + NWD'(sdo.det_m);
  assign numy = (NWD'(py) << 1) + NWD'(sdo.det_m);
  assign den  = {sdo.det_m, 1'b0};

  sgi_mul #(.A_WIDTH(2*MW), .B_WIDTH(LW), .LATENCY(LE)) u_mul_xs (
    .clk_i(clk_i), .en_i(en), .a_i(vs2), .b_i(sdo.la), .p_o(xs));
  sgi_mul #(.A_WIDTH(2*MW), .B_WIDTH(LW), .LATENCY(LE)) u_mul_xt (
    .clk_i(clk_i), .en_i(en), .a_i(vt2), .b_i(sdo.lb), .p_o(xt));
  sgi_mul #(.A_WIDTH(2*TW), .B_WIDTH(2*MW), .LATENCY(LE)) u_mul_y (
    .clk_i(clk_i), .en_i(en), .a_i(tol2), .b_i(det2), .p_o(yv));

  sgi_div #(.N_WIDTH(NWD), .D_WIDTH(MW+1), .Q_WIDTH(QW), .LATENCY(LE)) u_div_x (
    .clk_i(clk_i), .en_i(en), .num_i(numx), .den_i(den), .quo_o(qx), .ovf_o(ovfx));
  sgi_div #(.N_WIDTH(NWD), .D_WIDTH(MW+1), .Q_WIDTH(QW), .LATENCY(LE)) u_div_y (
    .clk_i(clk_i), .en_i(en), .num_i(numy), .den_i(den), .quo_o(qy), .ovf_o(ovfy));

  se_t se_q [LE];
  se_t se_in;
  assign se_in = '{zero: sdo.zero,
                   par: {sdo.det_m, {PAR_SHIFT{1'b0}}} < PCW'(thr_mn),
                   base_x: sdo.base_x, base_y: sdo.base_y,
                   neg_x: sdo.neg_x, neg_y: sdo.neg_y};

  // Decision and point sums, then the output register.
  logic                 hit5_q, ovfx5_q, ovfy5_q, negx5_q, negy5_q;
  logic signed [W+2:0]  sumx5_q, sumy5_q;
  logic signed [W+2:0]  offx, offy;
  se_t                  seo;
  logic                 out_hit_q;
  logic [W-1:0]         out_x_q, out_y_q;

  assign seo  = se_q[LE-1];
  assign offx = seo.neg_x ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
  assign offy = seo.neg_y ? -$signed({2'b00, qy}) : $signed({2'b00, qy});

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd_in;
      for (int i = 1; i < LD; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
      se_q[0] <= se_in;
      for (int i = 1; i < LE; i++) begin
        se_q[i] <= se_q[i-1];
      end

      hit5_q  <= !seo.zero && !seo.par && !(CW'(xs) > CW'(yv)) && !(CW'(xt) > CW'(yv));
      sumx5_q <= (W+3)'($signed(seo.base_x)) + offx;
      sumy5_q <= (W+3)'($signed(seo.base_y)) + offy;
      ovfx5_q <= ovfx;
      ovfy5_q <= ovfy;
      negx5_q <= seo.neg_x;
      negy5_q <= seo.neg_y;

      out_hit_q <= hit5_q;
      out_x_q   <= hit5_q ? sat_coord(sumx5_q, ovfx5_q, negx5_q) : '0;
      out_y_q   <= hit5_q ? sat_coord(sumy5_q, ovfy5_q, negy5_q) : '0;
    end
  end

  assign m_axis_tdata_o = TDW'({out_y_q, out_x_q});
  assign m_axis_tuser_o = out_hit_q;

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("miss result carries a nonzero point");

  a_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(en) |-> vld_q[0] == $past(s_axis_tvalid_i && rst_ni))
    else $error("first pipeline stage lost or invented a request");

  a_cfg_tol : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == CFG_TOL |=> tol_q == $past(cfg_data_i[TW-1:0]))
    else $error("tolerance write not taken");

endmodule

`default_nettype wire
